>>> hw/rtl/gga_pkg.sv
// shared types, constants and tag table for the gga sentence parser
`default_nettype none

package gga_pkg;

    localparam int TIME_CAPACITY_DEF = 16;
    localparam int LAT_CAPACITY_DEF  = 16;
    localparam int LON_CAPACITY_DEF  = 16;

    localparam int TAG_LEN = 7;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_TWO   = 8'h32;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TAKE  = 2'd1,
        KIND_INVAL = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OUTDATED = 2'd0,
        ST_UPDATING = 2'd1,
        ST_FRESH    = 2'd2,
        ST_UPTODATE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_TIME     = 3'd1,
        PH_LAT      = 3'd2,
        PH_LAT_HEMI = 3'd3,
        PH_LON      = 3'd4,
        PH_LON_HEMI = 3'd5,
        PH_QUAL     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        FLD_TIME = 2'd0,
        FLD_LAT  = 2'd1,
        FLD_LON  = 2'd2
    } t_field;

    // "$GPGGA," by position
    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            3'd6:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nmea_gga_sentence_parser_top.sv
// gga sentence parser: tag hunt, field capture, status and stored character reads
//
// slave side: one beat per item. s_tuser carries the kind (byte, take, invalidate,
// read); s_tdata carries the received byte, the store to read and the position.
// master side: exactly one result beat per accepted item, with the status after
// the item, the fix flag and the character read (zero for every other kind).
// each item is handled in the cycle it is accepted and its result sits in the
// output register from the next cycle on, one item per cycle while the receiver
// keeps up. the only storage path is the single write port of each field store
// beside the parser state, updated in that same cycle.
// s_tready is high whenever the output register is empty or being drained, so
// items follow back to back while the receiver keeps up; if the receiver holds
// m_tready low with a result pending, s_tready drops and the result holds.
// reset (synchronous, active low) empties the output register, returns the
// parser to tag hunting with status out of date and fix clear, and zeroes all
// three stores at once.
`default_nettype none

module nmea_gga_sentence_parser_top #(
    parameter int TIME_CAPACITY = gga_pkg::TIME_CAPACITY_DEF,
    parameter int LAT_CAPACITY  = gga_pkg::LAT_CAPACITY_DEF,
    parameter int LON_CAPACITY  = gga_pkg::LON_CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // rx_byte[7:0], read_field[9:8], read_index[13:10]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata    // data_status[1:0], fix_valid[2], read_char[10:3]
);

    localparam int MAX_CAP = (TIME_CAPACITY > LAT_CAPACITY)
        ? ((TIME_CAPACITY > LON_CAPACITY) ? TIME_CAPACITY : LON_CAPACITY)
        : ((LAT_CAPACITY > LON_CAPACITY) ? LAT_CAPACITY : LON_CAPACITY);
    localparam int PW  = $clog2(MAX_CAP + 1);
    localparam int TIW = $clog2(TIME_CAPACITY);
    localparam int AIW = $clog2(LAT_CAPACITY);
    localparam int OIW = $clog2(LON_CAPACITY);

    gga_pkg::t_phase  r_phase, n_phase;
    gga_pkg::t_status r_status, n_status;
    logic [PW-1:0]    r_pos, n_pos;
    logic             r_fix, n_fix;

    logic [7:0] r_time [TIME_CAPACITY];
    logic [7:0] r_lat  [LAT_CAPACITY];
    logic [7:0] r_lon  [LON_CAPACITY];

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic        r_out_fix;
    logic [7:0]  r_out_char;

    logic          w_accept;
    gga_pkg::t_kind w_kind;
    logic [7:0]    w_byte;
    logic [1:0]    w_field;
    logic [7:0]    w_ridx;
    logic          w_comma;
    logic          w_we_time, w_we_lat, w_we_lon;
    logic [PW-1:0] w_wpos;
    logic [7:0]    w_wdata;
    logic [7:0]    w_rd_char;

    assign s_tready = !r_out_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;
    assign w_kind   = gga_pkg::t_kind'(s_tuser);
    assign w_byte   = s_tdata[7:0];
    assign w_field  = s_tdata[9:8];
    assign w_ridx   = {4'b0000, s_tdata[13:10]};
    assign w_comma  = (w_byte == gga_pkg::CHAR_COMMA);

    // parser next state
    always_comb begin
        n_phase   = r_phase;
        n_status  = r_status;
        n_pos     = r_pos;
        n_fix     = r_fix;
        w_we_time = 1'b0;
        w_we_lat  = 1'b0;
        w_we_lon  = 1'b0;
        w_wpos    = r_pos;
        w_wdata   = w_byte;
        case (w_kind)
            gga_pkg::KIND_BYTE: begin
                if (r_status != gga_pkg::ST_UPTODATE) begin
                    case (r_phase)
                        gga_pkg::PH_TIME: begin
                            w_we_time = 1'b1;
                            if (w_comma) begin
                                w_wdata  = 8'h00;
                                n_phase  = gga_pkg::PH_LAT;
                                n_pos    = '0;
                                n_status = gga_pkg::ST_UPDATING;
                            end else if (r_pos < PW'(TIME_CAPACITY)) begin
                                n_pos = r_pos + PW'(1);
                            end
                        end
                        gga_pkg::PH_LAT, gga_pkg::PH_LAT_HEMI: begin
                            w_we_lat = 1'b1;
                            if (w_comma && r_phase == gga_pkg::PH_LAT_HEMI) begin
                                w_wdata = 8'h00;
                                n_phase = gga_pkg::PH_LON;
                                n_pos   = '0;
                            end else begin
                                if (r_pos < PW'(LAT_CAPACITY)) begin
                                    n_pos = r_pos + PW'(1);
                                end
                                if (w_comma) begin
                                    n_phase = gga_pkg::PH_LAT_HEMI;
                                end
                            end
                        end
                        gga_pkg::PH_LON, gga_pkg::PH_LON_HEMI: begin
                            w_we_lon = 1'b1;
                            if (w_comma && r_phase == gga_pkg::PH_LON_HEMI) begin
                                w_wdata = 8'h00;
                                n_phase = gga_pkg::PH_QUAL;
                                n_pos   = '0;
                            end else begin
                                if (r_pos < PW'(LON_CAPACITY)) begin
                                    n_pos = r_pos + PW'(1);
                                end
                                if (w_comma) begin
                                    n_phase = gga_pkg::PH_LON_HEMI;
                                end
                            end
                        end
                        gga_pkg::PH_QUAL: begin
                            if (w_comma) begin
                                n_phase  = gga_pkg::PH_HUNT;
                                n_status = gga_pkg::ST_FRESH;
                                n_pos    = '0;
                            end else begin
                                n_fix = (w_byte == gga_pkg::CHAR_ONE)
                                     || (w_byte == gga_pkg::CHAR_TWO);
                            end
                        end
                        default: begin
                            // tag hunt, unreachable code acts the same
                            if (r_pos < PW'(gga_pkg::TAG_LEN)) begin
                                if (w_byte == gga_pkg::tag_char(r_pos[2:0])) begin
                                    n_pos = r_pos + PW'(1);
                                end else begin
                                    n_pos = '0;
                                end
                            end else begin
                                w_we_time = 1'b1;
                                w_wpos    = '0;
                                n_pos     = PW'(1);
                                n_phase   = gga_pkg::PH_TIME;
                            end
                        end
                    endcase
                end
            end
            gga_pkg::KIND_TAKE: begin
                if (r_status == gga_pkg::ST_FRESH) begin
                    n_status = gga_pkg::ST_UPTODATE;
                end
            end
            gga_pkg::KIND_INVAL: begin
                n_status = gga_pkg::ST_OUTDATED;
            end
            default: begin
            end
        endcase
    end

    // stored character read
    always_comb begin
        w_rd_char = 8'h00;
        if (w_kind == gga_pkg::KIND_READ) begin
            case (w_field)
                gga_pkg::FLD_TIME: begin
                    if (w_ridx < 8'(TIME_CAPACITY)) begin
                        w_rd_char = r_time[w_ridx[TIW-1:0]];
                    end
                end
                gga_pkg::FLD_LAT: begin
                    if (w_ridx < 8'(LAT_CAPACITY)) begin
                        w_rd_char = r_lat[w_ridx[AIW-1:0]];
                    end
                end
                gga_pkg::FLD_LON: begin
                    if (w_ridx < 8'(LON_CAPACITY)) begin
                        w_rd_char = r_lon[w_ridx[OIW-1:0]];
                    end
                end
                default: begin
                    w_rd_char = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= gga_pkg::PH_HUNT;
            r_status <= gga_pkg::ST_OUTDATED;
            r_pos    <= '0;
            r_fix    <= 1'b0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_pos    <= n_pos;
            r_fix    <= n_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIME_CAPACITY; i++) r_time[i] <= 8'h00;
            for (int i = 0; i < LAT_CAPACITY; i++)  r_lat[i]  <= 8'h00;
            for (int i = 0; i < LON_CAPACITY; i++)  r_lon[i]  <= 8'h00;
        end else if (w_accept) begin
            if (w_we_time && w_wpos < PW'(TIME_CAPACITY)) begin
                r_time[w_wpos[TIW-1:0]] <= w_wdata;
            end
            if (w_we_lat && w_wpos < PW'(LAT_CAPACITY)) begin
                r_lat[w_wpos[AIW-1:0]] <= w_wdata;
            end
            if (w_we_lon && w_wpos < PW'(LON_CAPACITY)) begin
                r_lon[w_wpos[OIW-1:0]] <= w_wdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_status;
            r_out_fix    <= n_fix;
            r_out_char   <= w_rd_char;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'b00000, r_out_char, r_out_fix, r_out_status};

`ifndef ASSERT_OFF
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_CAP))
        else $error("write position beyond largest store");

    a_hunt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == gga_pkg::PH_HUNT |-> r_pos <= PW'(gga_pkg::TAG_LEN))
        else $error("tag match position beyond tag length");

    a_inval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_kind == gga_pkg::KIND_INVAL
        |=> m_tvalid && m_tdata[1:0] == gga_pkg::ST_OUTDATED)
        else $error("invalidate did not give out of date result");

    a_uptodate_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_kind == gga_pkg::KIND_BYTE && r_status == gga_pkg::ST_UPTODATE
        |=> r_phase == $past(r_phase) && r_pos == $past(r_pos) && r_fix == $past(r_fix))
        else $error("byte changed parser while up to date");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_kind != gga_pkg::KIND_READ |=> m_tdata[10:3] == 8'h00)
        else $error("non-read item returned a character");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// self-checking bench for the gga sentence parser: directed table, random sentences, random stalls
`default_nettype none

module tb;

    localparam int          CYCLE_LIMIT = 400_000;
    localparam int          ITEM_GOAL   = 1650;
    localparam int          TIME_CAP    = gga_pkg::TIME_CAPACITY_DEF;
    localparam int          LAT_CAP     = gga_pkg::LAT_CAPACITY_DEF;
    localparam int          LON_CAP     = gga_pkg::LON_CAPACITY_DEF;
    localparam logic [1:0]  FLD_NONE    = 2'd3;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_DOT    = 8'h2E;

    typedef struct {
        gga_pkg::t_status st;
        logic             fix;
        logic [7:0]       ch;
    } t_report;

    typedef struct {
        gga_pkg::t_kind   kind;
        logic [7:0]       rx;
        logic [1:0]       fld;
        logic [3:0]       idx;
        bit               typed;
        gga_pkg::t_status st;
        logic             fix;
        logic [7:0]       ch;
    } t_row;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // rx_byte[7:0], read_field[9:8], read_index[13:10]
    logic [1:0]  s_tuser  = gga_pkg::KIND_BYTE;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // data_status[1:0], fix_valid[2], read_char[10:3]

    // parser mirror
    gga_pkg::t_phase  pr_phase;
    logic [4:0]       pr_pos;
    gga_pkg::t_status pr_status;
    logic             pr_fix;
    logic [7:0]       pr_store [3][32];

    logic [7:0] gga_tag [7]    = '{"$", "G", "P", "G", "G", "A", ","};
    logic [7:0] hemi_chars [4] = '{"N", "S", "E", "W"};

    t_report     reports_due [$];
    int          bad_count    = 0;
    int          items_sent   = 0;
    int          beats_seen   = 0;
    int          sentences    = 0;
    int          reads_issued = 0;
    int unsigned cycle_count  = 0;
    bit          tx_idles     = 1'b1;
    bit          rx_idles     = 1'b1;

    t_row directed_rows [25] = '{
        '{gga_pkg::KIND_READ,  8'h00, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_READ,  8'h00, FLD_NONE, 4'd15,
          1'b1, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_TAKE,  8'h00, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  8'hFF, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  "$", gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  "G", gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  "P", gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  "G", gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  "G", gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  "A", gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_COMMA, gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_ONE, gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_COMMA, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_UPDATING, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_COMMA, gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_COMMA, gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_COMMA, gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_COMMA, gga_pkg::FLD_TIME, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_TWO, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_UPDATING, 1'b1, 8'h00},
        '{gga_pkg::KIND_BYTE,  gga_pkg::CHAR_COMMA, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_FRESH,    1'b1, 8'h00},
        '{gga_pkg::KIND_TAKE,  8'h00, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_UPTODATE, 1'b1, 8'h00},
        '{gga_pkg::KIND_BYTE,  8'h00, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_UPTODATE, 1'b1, 8'h00},
        '{gga_pkg::KIND_READ,  8'h00, gga_pkg::FLD_LAT, 4'd0,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_READ,  8'h00, gga_pkg::FLD_TIME, 4'd1,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00},
        '{gga_pkg::KIND_INVAL, 8'h00, gga_pkg::FLD_TIME, 4'd0,
          1'b1, gga_pkg::ST_OUTDATED, 1'b1, 8'h00},
        '{gga_pkg::KIND_READ,  8'h00, gga_pkg::FLD_LON, 4'd15,
          1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00}
    };

    nmea_gga_sentence_parser_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, reports_due.size());
            $display("tb: errors");
            $finish;
        end
    end

    function automatic int cap_of(input logic [1:0] fld);
        case (fld)
            gga_pkg::FLD_TIME: return TIME_CAP;
            gga_pkg::FLD_LAT:  return LAT_CAP;
            gga_pkg::FLD_LON:  return LON_CAP;
            default:           return 0;
        endcase
    endfunction

    // writes past capacity are dropped and the position stays put
    function automatic void store_char(input logic [1:0] fld, input logic [7:0] c);
        if (int'(pr_pos) < cap_of(fld)) begin
            pr_store[fld][pr_pos] = c;
            pr_pos++;
        end
    endfunction

    function automatic void close_field(input logic [1:0] fld);
        if (int'(pr_pos) < cap_of(fld))
            pr_store[fld][pr_pos] = 8'h00;
    endfunction

    function automatic void mirror_reset();
        pr_phase  = gga_pkg::PH_HUNT;
        pr_pos    = '0;
        pr_status = gga_pkg::ST_OUTDATED;
        pr_fix    = 1'b0;
        foreach (pr_store[f, i])
            pr_store[f][i] = 8'h00;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic comma;
        comma = (b == gga_pkg::CHAR_COMMA);
        case (pr_phase)
            gga_pkg::PH_TIME: begin
                if (comma) begin
                    close_field(gga_pkg::FLD_TIME);
                    pr_phase  = gga_pkg::PH_LAT;
                    pr_pos    = '0;
                    pr_status = gga_pkg::ST_UPDATING;
                end else begin
                    store_char(gga_pkg::FLD_TIME, b);
                end
            end
            gga_pkg::PH_LAT: begin
                store_char(gga_pkg::FLD_LAT, b);
                if (comma)
                    pr_phase = gga_pkg::PH_LAT_HEMI;
            end
            gga_pkg::PH_LAT_HEMI: begin
                if (comma) begin
                    close_field(gga_pkg::FLD_LAT);
                    pr_phase = gga_pkg::PH_LON;
                    pr_pos   = '0;
                end else begin
                    store_char(gga_pkg::FLD_LAT, b);
                end
            end
            gga_pkg::PH_LON: begin
                store_char(gga_pkg::FLD_LON, b);
                if (comma)
                    pr_phase = gga_pkg::PH_LON_HEMI;
            end
            gga_pkg::PH_LON_HEMI: begin
                if (comma) begin
                    close_field(gga_pkg::FLD_LON);
                    pr_phase = gga_pkg::PH_QUAL;
                    pr_pos   = '0;
                end else begin
                    store_char(gga_pkg::FLD_LON, b);
                end
            end
            gga_pkg::PH_QUAL: begin
                if (comma) begin
                    pr_phase  = gga_pkg::PH_HUNT;
                    pr_status = gga_pkg::ST_FRESH;
                    pr_pos    = '0;
                end else begin
                    pr_fix = (b == gga_pkg::CHAR_ONE) || (b == gga_pkg::CHAR_TWO);
                end
            end
            default: begin
                // a mismatching byte restarts the hunt and is not tried again
                if (int'(pr_pos) < gga_pkg::TAG_LEN) begin
                    if (b == gga_tag[pr_pos])
                        pr_pos++;
                    else
                        pr_pos = '0;
                end else begin
                    pr_store[gga_pkg::FLD_TIME][0] = b;
                    pr_pos   = 5'd1;
                    pr_phase = gga_pkg::PH_TIME;
                end
            end
        endcase
    endfunction

    function automatic t_report parse_step(input t_row r);
        t_report rep;
        rep.ch = 8'h00;
        case (r.kind)
            gga_pkg::KIND_BYTE:
                if (pr_status != gga_pkg::ST_UPTODATE) parse_byte(r.rx);
            gga_pkg::KIND_TAKE:
                if (pr_status == gga_pkg::ST_FRESH) pr_status = gga_pkg::ST_UPTODATE;
            gga_pkg::KIND_INVAL:
                pr_status = gga_pkg::ST_OUTDATED;
            default:
                if (int'(r.idx) < cap_of(r.fld)) rep.ch = pr_store[r.fld][r.idx];
        endcase
        rep.st  = pr_status;
        rep.fix = pr_fix;
        return rep;
    endfunction

    function automatic t_row plain_row(input gga_pkg::t_kind k, input logic [7:0] b,
                                       input logic [1:0] fld, input logic [3:0] idx);
        t_row r;
        r       = '{k, b, fld, idx, 1'b0, gga_pkg::ST_OUTDATED, 1'b0, 8'h00};
        return r;
    endfunction

    function automatic t_row random_row(input gga_pkg::t_kind k);
        return plain_row(k, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                         4'($urandom_range(0, 15)));
    endfunction

    function automatic void flag_error(input string what);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endfunction

    task automatic drive_row(input t_row r);
        int      gap;
        t_report rep;
        gap = tx_idles ? $urandom_range(0, 12) : 0;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {2'b00, r.idx, r.fld, r.rx};
        @(posedge i_clk);
        while (s_tready !== 1'b1)
            @(posedge i_clk);
        items_sent++;
        if (r.kind == gga_pkg::KIND_READ)
            reads_issued++;
        rep = parse_step(r);
        if (r.typed)
            reports_due.push_back(t_report'{r.st, r.fix, r.ch});
        else
            reports_due.push_back(rep);
    endtask

    function automatic logic [7:0] field_char(input bit wild);
        logic [7:0] c;
        if (wild)
            c = 8'($urandom_range(0, 255));
        else
            c = CHAR_ZERO + 8'($urandom_range(0, 9));
        if (c == gga_pkg::CHAR_COMMA)
            c = CHAR_DOT;
        return c;
    endfunction

    // mostly short fields, now and then long enough to overflow a store
    function automatic int field_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(14, 20);
        return $urandom_range(0, 10);
    endfunction

    task automatic send_sentence(input bit broken);
        logic [7:0] line [$];
        logic [7:0] q;
        bit         wild;
        int         spot;
        wild = ($urandom_range(0, 3) == 0);
        foreach (gga_tag[i])
            line.push_back(gga_tag[i]);
        for (int part = 0; part < 3; part++) begin
            repeat (field_len())
                line.push_back(field_char(wild));
            line.push_back(gga_pkg::CHAR_COMMA);
            if (part != 0) begin
                repeat ($urandom_range(0, 2))
                    line.push_back(hemi_chars[$urandom_range(0, 3)]);
                line.push_back(gga_pkg::CHAR_COMMA);
            end
        end
        repeat ($urandom_range(0, 2)) begin
            q = CHAR_ZERO + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                q = field_char(1'b1);
            line.push_back(q);
        end
        line.push_back(gga_pkg::CHAR_COMMA);
        repeat ($urandom_range(0, 12))
            line.push_back(8'($urandom_range(0, 255)));
        if (broken) begin
            spot = $urandom_range(0, line.size() - 1);
            if ($urandom_range(0, 1) == 1)
                line[spot] = 8'($urandom_range(0, 255));
            else
                while (line.size() > spot)
                    void'(line.pop_back());
        end
        foreach (line[i])
            drive_row(plain_row(gga_pkg::KIND_BYTE, line[i], 2'($urandom_range(0, 3)),
                                4'($urandom_range(0, 15))));
        sentences++;
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 12)) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
                b = gga_tag[$urandom_range(0, gga_pkg::TAG_LEN - 1)];
            drive_row(plain_row(gga_pkg::KIND_BYTE, b, gga_pkg::FLD_TIME, 4'd0));
        end
    endtask

    // result side
    initial begin : result_side
        t_report want;
        t_report got;
        int      stall;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            stall = rx_idles ? $urandom_range(0, 12) : 0;
            repeat (stall) begin
                m_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (m_tvalid !== 1'b1)
                @(posedge i_clk);
            got.st  = gga_pkg::t_status'(m_tdata[1:0]);
            got.fix = m_tdata[2];
            got.ch  = m_tdata[10:3];
            beats_seen++;
            if (reports_due.size() == 0) begin
                flag_error($sformatf("result beat %h with nothing outstanding", m_tdata));
            end else begin
                want = reports_due.pop_front();
                if (got.st !== want.st)
                    flag_error($sformatf("beat %0d status exp %0d got %0d",
                                         beats_seen, want.st, got.st));
                if (got.fix !== want.fix)
                    flag_error($sformatf("beat %0d fix exp %0b got %0b",
                                         beats_seen, want.fix, got.fix));
                if (got.ch !== want.ch)
                    flag_error($sformatf("beat %0d char exp %h got %h",
                                         beats_seen, want.ch, got.ch));
            end
        end
    end

    // stimulus
    initial begin : item_side
        int pick;
        mirror_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_row(directed_rows[i]);

        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 4) == 0) begin
                pick     = $urandom_range(0, 3);
                tx_idles = (pick == 1) || (pick == 2);
                rx_idles = (pick == 1) || (pick == 3);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_noise();
            else
                send_sentence(pick <= 2);
            repeat ($urandom_range(0, 3))
                drive_row(random_row(gga_pkg::KIND_READ));
            if ($urandom_range(0, 2) != 0)
                drive_row(random_row(gga_pkg::KIND_TAKE));
            repeat ($urandom_range(0, 4))
                drive_row(random_row(gga_pkg::KIND_READ));
            // leaving the data up to date lets the next bytes be ignored
            if ($urandom_range(0, 9) < 7)
                drive_row(random_row(gga_pkg::KIND_INVAL));
        end
        s_tvalid <= 1'b0;

        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("summary: %0d items, %0d sentences, %0d reads, %0d result beats",
                 items_sent, sentences, reads_issued, beats_seen);
        $display("summary: %0d mismatches over %0d cycles", bad_count, cycle_count);
        if (bad_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
